FILE: src/ssam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssam_pkg: shared types and constants of the strided slice address map
// Field widths, register indexes and the per-dimension job handed from the
// front classifier to the back pipeline.
// ----------------------------------------------------------------------------
package ssam_pkg;

	localparam int NDIM         = 4;
	localparam int NDIM_IDX_W   = 2;
	localparam int COORD_W      = 16;
	localparam int DIST_W       = 16;
	localparam int WIN_W        = 48;
	localparam int ADDR_W       = 32;
	localparam int DATA_W       = 32;
	localparam int CFG_IDX_W    = 4;
	localparam int DIV_STEPS    = DIST_W;
	localparam int MID_DEPTH    = 4;
	localparam int OUT_DEPTH    = 4;

	localparam int ELEM_WIDTH_DEF = 32;
	localparam int RANK_DEF       = 4;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_WIN_BASE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_BASE = CFG_IDX_W'(NDIM);
	localparam logic [CFG_IDX_W-1:0] REG_COUNT      = CFG_IDX_W'(2 * NDIM);

	// begin 0, end 32767, stride 1
	localparam logic [WIN_W-1:0] WIN_RESET = 48'h0001_7FFF_0000;

	// one dimension's work for the divider: offset from begin and stride magnitude
	typedef struct packed {
		logic [DIST_W-1:0] span;
		logic [DIST_W-1:0] step;
	} dim_job_t;

	localparam int JOB_W = 2 * DIST_W;

endpackage

FILE: src/ssam_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssam_fifo: small register queue
// Holds items between the front and back parts and in front of the result
// ports; head is read directly from the storage at the read pointer.
// ----------------------------------------------------------------------------
module ssam_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             pop,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: src/ssam_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssam_front: window check and offset setup
// Checks each coordinate against its begin/end window for the stride sign and
// forms the offset and stride magnitude that the back part divides.
// ----------------------------------------------------------------------------
module ssam_front #(
	parameter int RANK = ssam_pkg::RANK_DEF
) (
	input  logic [ssam_pkg::COORD_W-1:0]      coord [ssam_pkg::NDIM],
	input  logic [ssam_pkg::WIN_W-1:0]        win   [ssam_pkg::NDIM],
	output ssam_pkg::dim_job_t [RANK-1:0]     jobs,
	output logic                              pass
);

	always_comb begin
		logic signed [ssam_pkg::COORD_W:0] c;
		logic signed [ssam_pkg::COORD_W:0] b;
		logic signed [ssam_pkg::COORD_W:0] e;
		logic signed [ssam_pkg::COORD_W:0] s;
		logic signed [ssam_pkg::COORD_W:0] d;
		logic signed [ssam_pkg::COORD_W:0] m;
		logic                              ok;
		pass = 1'b1;
		jobs = '0;
		for (int k = 0; k < RANK; k++) begin
			c = $signed({1'b0, coord[k]});
			b = $signed({win[k][15], win[k][15:0]});
			e = $signed({win[k][31], win[k][31:16]});
			s = $signed({win[k][47], win[k][47:32]});
			// mirror the window for a negative stride; zero stride never passes
			if (s == '0) begin
				ok = 1'b0;
				d  = '0;
				m  = '0;
			end else if (s[ssam_pkg::COORD_W]) begin
				ok = (c > e) && (c <= b);
				d  = b - c;
				m  = -s;
			end else begin
				ok = (c >= b) && (c < e);
				d  = c - b;
				m  = s;
			end
			jobs[k].span = d[ssam_pkg::DIST_W-1:0];
			jobs[k].step = m[ssam_pkg::DIST_W-1:0];
			pass = pass & ok;
		end
	end

endmodule

FILE: src/ssam_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssam_back: divide, multiply and sum pipeline
// Restoring division one quotient bit per stage for every dimension, an exact
// remainder check, quotient times output pitch, and a two-level adder tree.
// ----------------------------------------------------------------------------
module ssam_back #(
	parameter int RANK  = ssam_pkg::RANK_DEF,
	parameter int VAL_W = ssam_pkg::DATA_W
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  ssam_pkg::dim_job_t [RANK-1:0]      in_jobs,
	input  logic [VAL_W-1:0]                   in_value,
	input  logic [ssam_pkg::ADDR_W-1:0]        pitch [ssam_pkg::NDIM],
	input  logic                               stall,
	output logic                               in_pop,
	output logic                               res_push,
	output logic [ssam_pkg::ADDR_W-1:0]        res_addr,
	output logic [VAL_W-1:0]                   res_value
);

	localparam int DW    = ssam_pkg::DIST_W;
	localparam int AW    = ssam_pkg::ADDR_W;
	localparam int STEPS = ssam_pkg::DIV_STEPS;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [DW-1:0] quo;
		logic [DW-1:0] num;
		logic [DW-1:0] den;
	} div_lane_t;

	function automatic div_lane_t div_step(input div_lane_t cur);
		logic [DW:0] trial;
		div_lane_t   nxt;
		trial = {cur.rem, cur.num[DW-1]};
		nxt   = cur;
		nxt.num = {cur.num[DW-2:0], 1'b0};
		if (trial >= {1'b0, cur.den}) begin
			trial   = trial - {1'b0, cur.den};
			nxt.quo = {cur.quo[DW-2:0], 1'b1};
		end else begin
			nxt.quo = {cur.quo[DW-2:0], 1'b0};
		end
		nxt.rem = trial[DW-1:0];
		return nxt;
	endfunction

	logic                        advance;
	div_lane_t [RANK-1:0]        div_nxt [STEPS];
	logic                        rem_ok;
	logic [AW-1:0]               prod_pad [ssam_pkg::NDIM];

	// divider stages: _s1[j] holds the state after j+1 quotient bits
	logic                        vld_s1 [STEPS];
	div_lane_t [RANK-1:0]        div_s1 [STEPS];
	logic [VAL_W-1:0]            val_s1 [STEPS];
	// products
	logic                        vld_s2;
	logic [AW-1:0]               prod_s2 [RANK];
	logic [VAL_W-1:0]            val_s2;
	// pair sums
	logic                        vld_s3;
	logic [AW-1:0]               pair_s3 [2];
	logic [VAL_W-1:0]            val_s3;
	// final address
	logic                        vld_s4;
	logic [AW-1:0]               addr_s4;
	logic [VAL_W-1:0]            val_s4;

	assign advance   = !stall;
	assign in_pop    = advance && in_valid;
	assign res_push  = advance && vld_s4;
	assign res_addr  = addr_s4;
	assign res_value = val_s4;

	always_comb begin
		div_lane_t src;
		for (int j = 0; j < STEPS; j++) begin
			for (int k = 0; k < RANK; k++) begin
				if (j == 0) begin
					src.rem = '0;
					src.quo = '0;
					src.num = in_jobs[k].span;
					src.den = in_jobs[k].step;
				end else begin
					src = div_s1[j-1][k];
				end
				div_nxt[j][k] = div_step(src);
			end
		end
	end

	always_comb begin
		rem_ok = 1'b1;
		for (int k = 0; k < RANK; k++) begin
			rem_ok = rem_ok & (div_s1[STEPS-1][k].rem == '0);
		end
	end

	always_comb begin
		prod_pad = '{default: '0};
		for (int k = 0; k < RANK; k++) begin
			prod_pad[k] = prod_s2[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < STEPS; j++) begin
				vld_s1[j] <= 1'b0;
			end
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (advance) begin
			vld_s1[0] <= in_valid;
			for (int j = 1; j < STEPS; j++) begin
				vld_s1[j] <= vld_s1[j-1];
			end
			// drop items whose offset is not a whole number of strides
			vld_s2 <= vld_s1[STEPS-1] && rem_ok;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int j = 0; j < STEPS; j++) begin
				div_s1[j] <= div_nxt[j];
			end
			val_s1[0] <= in_value;
			for (int j = 1; j < STEPS; j++) begin
				val_s1[j] <= val_s1[j-1];
			end
			for (int k = 0; k < RANK; k++) begin
				prod_s2[k] <= AW'(div_s1[STEPS-1][k].quo * pitch[k]);
			end
			val_s2     <= val_s1[STEPS-1];
			pair_s3[0] <= prod_pad[0] + prod_pad[1];
			pair_s3[1] <= prod_pad[2] + prod_pad[3];
			val_s3     <= val_s2;
			addr_s4    <= pair_s3[0] + pair_s3[1];
			val_s4     <= val_s3;
		end
	end

endmodule

FILE: src/strided_slice_address_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_slice_address_map: element filter and output address generator
// Keeps the tensor elements that fall on a strided slice and maps each kept
// element to its offset in the output tensor.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Payload
// -------   ---------  ------------------  ------------------------------------
// input     in         push / full         coord0..coord3, elem_value
// result    out        empty / pop         dest_addr, dest_value
// config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Throughput is one item per cycle while the result queue is not full. An item
// that passes goes through the middle queue, the 16-stage divider pipeline (one
// quotient bit per stage), one multiply stage, two adder stages and the write
// into the result queue before it can be popped.
// Reset clears both queues and the back pipeline, and loads every window with
// begin 0, end 32767, stride 1 and every output pitch with 0.
// A full result queue freezes the back pipeline; the middle queue then fills
// and full rises. Items rejected by the window check never enter the pipeline.
//
module strided_slice_address_map #(
	parameter int ELEM_WIDTH = ssam_pkg::ELEM_WIDTH_DEF,
	parameter int RANK       = ssam_pkg::RANK_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              push,
	output logic                              full,
	input  logic [ssam_pkg::COORD_W-1:0]      coord0,
	input  logic [ssam_pkg::COORD_W-1:0]      coord1,
	input  logic [ssam_pkg::COORD_W-1:0]      coord2,
	input  logic [ssam_pkg::COORD_W-1:0]      coord3,
	input  logic [ssam_pkg::DATA_W-1:0]       elem_value,
	// result items
	output logic                              empty,
	input  logic                              pop,
	output logic [ssam_pkg::ADDR_W-1:0]       dest_addr,
	output logic [ssam_pkg::DATA_W-1:0]       dest_value,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ssam_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssam_pkg::WIN_W-1:0]        cfg_data
);

	// only the low ELEM_WIDTH bits of a value survive, and at most 32 of them
	localparam int VAL_W   = (ELEM_WIDTH < ssam_pkg::DATA_W) ? ELEM_WIDTH : ssam_pkg::DATA_W;
	localparam int MID_W   = RANK * ssam_pkg::JOB_W + VAL_W;
	localparam int OUT_W   = ssam_pkg::ADDR_W + VAL_W;
	localparam int DW      = ssam_pkg::DATA_W;

	logic [ssam_pkg::WIN_W-1:0]      win_q   [ssam_pkg::NDIM];
	logic [ssam_pkg::ADDR_W-1:0]     pitch_q [ssam_pkg::NDIM];

	logic [ssam_pkg::COORD_W-1:0]    coord_vec [ssam_pkg::NDIM];
	ssam_pkg::dim_job_t [RANK-1:0]   front_jobs;
	logic                            front_pass;

	logic                            mid_push;
	logic                            mid_pop;
	logic                            mid_full;
	logic                            mid_empty;
	logic [MID_W-1:0]                mid_rdata;
	ssam_pkg::dim_job_t [RANK-1:0]   mid_jobs;
	logic [VAL_W-1:0]                mid_value;

	logic                            out_push;
	logic                            out_full;
	logic [ssam_pkg::ADDR_W-1:0]     res_addr;
	logic [VAL_W-1:0]                res_value;
	logic [OUT_W-1:0]                out_rdata;
	logic [VAL_W-1:0]                out_value;

	// --- configuration registers; writes are always taken ---
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ssam_pkg::NDIM; k++) begin
				win_q[k]   <= ssam_pkg::WIN_RESET;
				pitch_q[k] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			// indexes past the last pitch register fall through: drop the write
			if (cfg_index < ssam_pkg::REG_PITCH_BASE) begin
				win_q[cfg_index[ssam_pkg::NDIM_IDX_W-1:0]] <= cfg_data;
			end else if (cfg_index < ssam_pkg::REG_COUNT) begin
				pitch_q[cfg_index[ssam_pkg::NDIM_IDX_W-1:0]] <=
					cfg_data[ssam_pkg::ADDR_W-1:0];
			end
		end
	end

	// --- front: check windows, form offsets ---
	assign coord_vec[0] = coord0;
	assign coord_vec[1] = coord1;
	assign coord_vec[2] = coord2;
	assign coord_vec[3] = coord3;

	ssam_front #(
		.RANK (RANK)
	) u_front (
		.coord (coord_vec),
		.win   (win_q),
		.jobs  (front_jobs),
		.pass  (front_pass)
	);

	// accept whenever the middle queue has room; enqueue only passing items
	assign full     = mid_full;
	assign mid_push = push && !mid_full && front_pass;

	ssam_fifo #(
		.WIDTH (MID_W),
		.DEPTH (ssam_pkg::MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.pop    (mid_pop),
		.wdata  ({elem_value[VAL_W-1:0], front_jobs}),
		.rdata  (mid_rdata),
		.full   (mid_full),
		.empty  (mid_empty)
	);

	assign mid_jobs  = mid_rdata[RANK*ssam_pkg::JOB_W-1:0];
	assign mid_value = mid_rdata[MID_W-1:RANK*ssam_pkg::JOB_W];

	// --- back: divide, check remainder, multiply, sum ---
	ssam_back #(
		.RANK  (RANK),
		.VAL_W (VAL_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!mid_empty),
		.in_jobs   (mid_jobs),
		.in_value  (mid_value),
		.pitch     (pitch_q),
		.stall     (out_full),
		.in_pop    (mid_pop),
		.res_push  (out_push),
		.res_addr  (res_addr),
		.res_value (res_value)
	);

	// --- result queue ---
	ssam_fifo #(
		.WIDTH (OUT_W),
		.DEPTH (ssam_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.pop    (pop && !empty),
		.wdata  ({res_value, res_addr}),
		.rdata  (out_rdata),
		.full   (out_full),
		.empty  (empty)
	);

	assign dest_addr  = out_rdata[ssam_pkg::ADDR_W-1:0];
	assign out_value  = out_rdata[OUT_W-1:ssam_pkg::ADDR_W];
	assign dest_value = DW'(out_value);

	// --- checks ---
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result queue written while full");

	a_mid_pop_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> (!mid_empty && !out_full))
		else $error("middle queue popped while empty or back stalled");

	a_rejected_not_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !front_pass) |-> !mid_push)
		else $error("item outside its window entered the pipeline");

	a_cfg_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index >= ssam_pkg::REG_COUNT) |=>
			($stable(win_q[0]) && $stable(pitch_q[0]) &&
			 $stable(win_q[3]) && $stable(pitch_q[3])))
		else $error("write past the register map changed a register");

endmodule

FILE: tb/sv/slice_map_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slice_map_checker: result checker for the strided slice address map
// Watches the item, result and register channels, keeps a shadow copy of the
// slice registers, predicts the output address of every kept element and
// compares each popped result with the oldest prediction.
// ----------------------------------------------------------------------------
module slice_map_checker #(
	parameter int ELEM_WIDTH = ssam_pkg::ELEM_WIDTH_DEF,
	parameter int RANK       = ssam_pkg::RANK_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic                              full,
	input  logic [ssam_pkg::COORD_W-1:0]      coord0,
	input  logic [ssam_pkg::COORD_W-1:0]      coord1,
	input  logic [ssam_pkg::COORD_W-1:0]      coord2,
	input  logic [ssam_pkg::COORD_W-1:0]      coord3,
	input  logic [ssam_pkg::DATA_W-1:0]       elem_value,
	input  logic                              empty,
	input  logic                              pop,
	input  logic [ssam_pkg::ADDR_W-1:0]       dest_addr,
	input  logic [ssam_pkg::DATA_W-1:0]       dest_value,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [ssam_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssam_pkg::WIN_W-1:0]        cfg_data,
	output int                                mismatch_count,
	output int                                pending_count
);

	typedef struct packed {
		logic [ssam_pkg::ADDR_W-1:0] addr;
		logic [ssam_pkg::DATA_W-1:0] value;
	} kept_elem_t;

	localparam logic [63:0] VALUE_MASK =
		(ELEM_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << ELEM_WIDTH) - 64'd1);

	logic [ssam_pkg::WIN_W-1:0]  win_shadow   [ssam_pkg::NDIM];
	logic [ssam_pkg::ADDR_W-1:0] pitch_shadow [ssam_pkg::NDIM];
	kept_elem_t                  kept_q [$];
	int                          fail_tally;

	// Returns 1 when the element falls on the slice in every checked dimension.
	function automatic bit map_element(input logic [4*ssam_pkg::COORD_W-1:0] crd,
			output logic [ssam_pkg::ADDR_W-1:0] addr);
		int k;
		int c;
		int start_pos;
		int stop_pos;
		int step_val;
		logic [31:0] span;
		logic [31:0] mag;
		addr = '0;
		for (k = 0; k < RANK && k < ssam_pkg::NDIM; k++) begin
			c         = int'(crd[ssam_pkg::COORD_W*k +: ssam_pkg::COORD_W]);
			start_pos = int'($signed(win_shadow[k][15:0]));
			stop_pos  = int'($signed(win_shadow[k][31:16]));
			step_val  = int'($signed(win_shadow[k][47:32]));
			if (step_val > 0) begin
				if (c < start_pos || c >= stop_pos)
					return 1'b0;
				span = 32'(c - start_pos);
				mag  = 32'(step_val);
			end else if (step_val < 0) begin
				// mirrored window: (stop, start]
				if (c <= stop_pos || c > start_pos)
					return 1'b0;
				span = 32'(start_pos - c);
				mag  = 32'(-step_val);
			end else begin
				return 1'b0;
			end
			if (span % mag != 0)
				return 1'b0;
			addr = addr + (span / mag) * pitch_shadow[k];
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		kept_elem_t oldest;
		kept_elem_t fresh;
		logic [ssam_pkg::ADDR_W-1:0] addr;
		logic [ssam_pkg::CFG_IDX_W-1:0] rel;
		if (!arst_n) begin
			for (int k = 0; k < ssam_pkg::NDIM; k++) begin
				win_shadow[k]   = ssam_pkg::WIN_RESET;
				pitch_shadow[k] = '0;
			end
			kept_q.delete();
			pending_count  <= 0;
			mismatch_count <= fail_tally;
		end else begin
			// results first: an item pushed at this edge cannot already be out
			if (pop && !empty) begin
				if (kept_q.size() == 0) begin
					fail_tally++;
					$display("%0t: result with nothing expected: addr %h value %h",
						$time, dest_addr, dest_value);
				end else begin
					oldest = kept_q.pop_front();
					if (dest_addr !== oldest.addr) begin
						fail_tally++;
						$display("%0t: dest_addr expected %h, got %h",
							$time, oldest.addr, dest_addr);
					end
					if (dest_value !== oldest.value) begin
						fail_tally++;
						$display("%0t: dest_value expected %h, got %h",
							$time, oldest.value, dest_value);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < ssam_pkg::REG_PITCH_BASE) begin
					rel = cfg_index - ssam_pkg::REG_WIN_BASE;
					win_shadow[rel[ssam_pkg::NDIM_IDX_W-1:0]] = cfg_data;
				end else if (cfg_index < ssam_pkg::REG_COUNT) begin
					rel = cfg_index - ssam_pkg::REG_PITCH_BASE;
					pitch_shadow[rel[ssam_pkg::NDIM_IDX_W-1:0]] =
						cfg_data[ssam_pkg::ADDR_W-1:0];
				end
			end
			if (push && !full) begin
				if (map_element({coord3, coord2, coord1, coord0}, addr)) begin
					fresh.addr  = addr;
					fresh.value = 32'({32'h0, elem_value} & VALUE_MASK);
					kept_q.push_back(fresh);
				end
			end
			pending_count  <= kept_q.size();
			mismatch_count <= fail_tally;
		end
	end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for the strided slice address map
// Drives tensor elements and slice register settings into the block, drains
// the results under random back-pressure and leaves all checking to the
// slice map checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb;

	localparam int RESET_CYCLES  = 3;
	localparam int RANDOM_PHASES = 13;
	localparam int PHASE_ITEMS   = 150;
	// wait after draining so the pipeline is empty before a register write
	localparam int SETTLE_CYCLES = 32;
	localparam int LONG_HOLD     = 400;
	// cycle limit for the watchdog below
	localparam int CYCLE_LIMIT   = 1_000_000;

	typedef enum int {SLICE_CFG, EXTREME_CFG, NOISE_CFG} window_kind_t;

	logic                              clk;
	logic                              arst_n;
	logic                              push;
	logic                              full;
	logic [ssam_pkg::COORD_W-1:0]      coord0;
	logic [ssam_pkg::COORD_W-1:0]      coord1;
	logic [ssam_pkg::COORD_W-1:0]      coord2;
	logic [ssam_pkg::COORD_W-1:0]      coord3;
	logic [ssam_pkg::DATA_W-1:0]       elem_value;
	logic                              empty;
	logic                              pop;
	logic [ssam_pkg::ADDR_W-1:0]       dest_addr;
	logic [ssam_pkg::DATA_W-1:0]       dest_value;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [ssam_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [ssam_pkg::WIN_W-1:0]        cfg_data;

	int mismatch_count;
	int pending_count;
	int cycle_count;

	// slice settings the stimulus aims at; loaded into the block by load_slice
	int                          cur_start [ssam_pkg::NDIM];
	int                          cur_stop  [ssam_pkg::NDIM];
	int                          cur_step  [ssam_pkg::NDIM];
	logic [ssam_pkg::ADDR_W-1:0] cur_pitch [ssam_pkg::NDIM];

	// idling controls: the sender's own flag, and two signals read by the drain
	bit   sender_idle;
	logic result_idle;
	int   hold_ticket;

	strided_slice_address_map DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.coord0     (coord0),
		.coord1     (coord1),
		.coord2     (coord2),
		.coord3     (coord3),
		.elem_value (elem_value),
		.empty      (empty),
		.pop        (pop),
		.dest_addr  (dest_addr),
		.dest_value (dest_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	slice_map_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.coord0         (coord0),
		.coord1         (coord1),
		.coord2         (coord2),
		.coord3         (coord3),
		.elem_value     (elem_value),
		.empty          (empty),
		.pop            (pop),
		.dest_addr      (dest_addr),
		.dest_value     (dest_value),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Mostly back-to-back, some short gaps, a few long ones; none when sender_idle is low.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!sender_idle || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Pick a coordinate along dimension k: mostly one that lands on the slice,
	// some near misses around the start, a few anywhere in the 16-bit range.
	function automatic logic [15:0] pick_coord(input int k);
		int s;
		int e;
		int st;
		int a;
		int lo;
		int hi;
		int n;
		int r;
		s  = cur_start[k];
		e  = cur_stop[k];
		st = cur_step[k];
		a  = (st < 0) ? -st : st;
		lo = 0;
		hi = -1;
		r  = $urandom_range(0, 99);
		if (st > 0) begin
			lo = (s < 0) ? (-s + st - 1) / st : 0;
			if (e - 1 >= s)
				hi = (e - 1 - s) / st;
		end else if (st < 0) begin
			if (s >= 0 && s > e) begin
				hi = (s - e - 1) / a;
				if (s / a < hi)
					hi = s / a;
			end
		end
		if (r < 90 && hi >= lo) begin
			n = lo + int'($urandom_range(0, hi - lo));
			return (st > 0) ? 16'(s + st * n) : 16'(s - a * n);
		end
		if (r < 96)
			return 16'(s + int'($urandom_range(0, 8)) - 4);
		return 16'($urandom());
	endfunction

	task automatic set_dim(input int k, input int s, input int e, input int st);
		cur_start[k] = s;
		cur_stop[k]  = e;
		cur_step[k]  = st;
	endtask

	// Draw one dimension's window and pitch for a random phase.
	task automatic pick_dim(input int k, input window_kind_t kind);
		int r;
		int mag;
		r = $urandom_range(0, 99);
		case (kind)
			SLICE_CFG: begin
				mag = (r < 80) ? int'($urandom_range(1, 5)) :
					(r < 90) ? 1 : int'($urandom_range(6, 300));
				if ($urandom_range(0, 1) == 0) begin
					cur_start[k] = ($urandom_range(0, 9) == 0) ?
						int'($urandom_range(0, 32000)) : int'($urandom_range(0, 210)) - 10;
					cur_stop[k] = cur_start[k] + int'($urandom_range(1, 400));
					if (cur_stop[k] > 32767)
						cur_stop[k] = 32767;
					cur_step[k] = mag;
				end else begin
					cur_start[k] = ($urandom_range(0, 9) == 0) ?
						int'($urandom_range(400, 32767)) : int'($urandom_range(0, 400));
					cur_stop[k] = cur_start[k] - int'($urandom_range(1, 400));
					cur_step[k] = -mag;
				end
			end
			EXTREME_CFG: begin
				case ($urandom_range(0, 4))
					0: set_dim(k, 0, 32767, 1);
					1: set_dim(k, 32767, -32768, -32768);
					2: set_dim(k, -32768, 32767, 32767);
					3: set_dim(k, 32767, -1, -1);
					default: set_dim(k, -32768, 32767, 1);
				endcase
			end
			default: begin
				cur_start[k] = int'($signed(16'($urandom())));
				cur_stop[k]  = int'($signed(16'($urandom())));
				cur_step[k]  = int'($signed(16'($urandom())));
			end
		endcase
		r = $urandom_range(0, 9);
		cur_pitch[k] = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF :
			(r < 4) ? 32'($urandom()) : 32'($urandom_range(1, 64));
	endtask

	// Hold valid high across back-to-back writes; the caller drops it.
	task automatic write_reg(input logic [ssam_pkg::CFG_IDX_W-1:0] idx,
			input logic [ssam_pkg::WIN_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write every register from the cur_* settings. Lead with a write to an
	// unmapped index, and pad the pitch writes with junk in the upper bits.
	task automatic load_slice();
		write_reg(ssam_pkg::REG_COUNT + ssam_pkg::CFG_IDX_W'($urandom_range(0, 7)),
			48'({$urandom(), $urandom()}));
		for (int k = 0; k < ssam_pkg::NDIM; k++)
			write_reg(ssam_pkg::REG_WIN_BASE + ssam_pkg::CFG_IDX_W'(k),
				{16'(cur_step[k]), 16'(cur_stop[k]), 16'(cur_start[k])});
		for (int k = 0; k < ssam_pkg::NDIM; k++)
			write_reg(ssam_pkg::REG_PITCH_BASE + ssam_pkg::CFG_IDX_W'(k),
				{16'($urandom()), cur_pitch[k]});
		cfg_valid <= 1'b0;
	endtask

	// Offer one item and wait for it to be taken; leave push high on a zero gap
	// so the next item follows without a bubble.
	task automatic push_item(input logic [15:0] c0, input logic [15:0] c1,
			input logic [15:0] c2, input logic [15:0] c3, input logic [31:0] val);
		int gap;
		push       <= 1'b1;
		coord0     <= c0;
		coord1     <= c1;
		coord2     <= c2;
		coord3     <= c3;
		elem_value <= val;
		do @(posedge clk); while (full);
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending, wait until every kept element has been popped, then let
	// the pipeline settle so the block is idle for a register write.
	task automatic wait_drain();
		push <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: pop with random stalls, or always pop when result_idle is
	// low. A new hold_ticket starts a long hold, counted here, that lets the
	// result queue fill and back-pressure reach the input.
	initial begin : result_drain
		int stall_left;
		int seen_ticket;
		int r;
		stall_left  = 0;
		seen_ticket = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ticket != seen_ticket) begin
				seen_ticket = hold_ticket;
				stall_left  = LONG_HOLD;
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else if (!result_idle) begin
				pop <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					pop <= 1'b1;
				end else begin
					pop <= 1'b0;
					stall_left = (r < 97) ? int'($urandom_range(0, 2)) :
						int'($urandom_range(10, 60));
				end
			end
		end
	end

	initial begin : stimulus
		int ph;
		window_kind_t kind;
		arst_n      <= 1'b0;
		push        <= 1'b0;
		coord0      <= '0;
		coord1      <= '0;
		coord2      <= '0;
		coord3      <= '0;
		elem_value  <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		result_idle <= 1'b1;
		hold_ticket <= 0;
		sender_idle = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: window [0, 32767) with unit stride, all pitches zero.
		push_item(16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0000);
		push_item(16'd32766, 16'd32766, 16'd32766, 16'd32766, 32'hFFFF_FFFF);
		push_item(16'd32767, 16'd0, 16'd0, 16'd0, 32'h1234_5678);
		push_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hAAAA_AAAA);
		push_item(16'd1, 16'd2, 16'd3, 16'd4, 32'h5555_5555);
		wait_drain();

		// Mixed slice: positive stride, mirrored window with a negative end,
		// negative start, full range; pitches large enough to wrap the address.
		set_dim(0, 2, 20, 3);
		set_dim(1, 10, -1, -2);
		set_dim(2, -5, 7, 4);
		set_dim(3, 0, 32767, 1);
		cur_pitch[0] = 32'hFFFF_FFFF;
		cur_pitch[1] = 32'd1000;
		cur_pitch[2] = 32'h8000_0000;
		cur_pitch[3] = 32'd7;
		load_slice();
		push_item(16'd2, 16'd10, 16'd3, 16'd5, 32'hDEAD_BEEF);
		push_item(16'd17, 16'd0, 16'd3, 16'd100, 32'h0F0F_0F0F);
		push_item(16'd17, 16'd0, 16'd3, 16'hFFFF, 32'h0000_0001);
		push_item(16'd20, 16'd10, 16'd3, 16'd0, 32'h8000_0000);
		push_item(16'd3, 16'd10, 16'd3, 16'd0, 32'h7FFF_FFFF);
		push_item(16'd2, 16'd11, 16'd3, 16'd0, 32'hCAFE_F00D);
		push_item(16'd2, 16'd9, 16'd7, 16'd0, 32'h0123_4567);
		wait_drain();

		// Zero stride drops everything.
		set_dim(0, 2, 20, 0);
		load_slice();
		push_item(16'd2, 16'd10, 16'd3, 16'd0, 32'h1111_1111);
		push_item(16'd0, 16'd0, 16'd0, 16'd0, 32'h2222_2222);
		wait_drain();

		// Negative end with a positive stride drops everything.
		set_dim(0, 2, 20, 3);
		set_dim(1, -3, -1, 1);
		load_slice();
		push_item(16'd2, 16'd0, 16'd3, 16'd0, 32'h3333_3333);
		push_item(16'd5, 16'd1, 16'd3, 16'd0, 32'h4444_4444);
		wait_drain();

		// Field extremes: strides of -32768 and 32767, bounds at both limits.
		set_dim(0, 32767, -32768, -32768);
		set_dim(1, -32768, 32767, 32767);
		set_dim(2, 32767, -1, -1);
		set_dim(3, 0, 32767, 1);
		for (int k = 0; k < ssam_pkg::NDIM; k++)
			cur_pitch[k] = 32'hFFFF_FFFF;
		load_slice();
		push_item(16'd32767, 16'd32766, 16'd0, 16'd32766, 32'hFFFF_FFFF);
		push_item(16'd0, 16'd32766, 16'd0, 16'd0, 32'h0000_0000);
		push_item(16'd32767, 16'd0, 16'd32767, 16'd0, 32'h9999_9999);
		push_item(16'd32767, 16'd32766, 16'd32767, 16'd0, 32'h6666_6666);
		wait_drain();

		// Random phases: a fresh slice per phase, mostly elements that land on
		// it. Every fourth phase runs with no idling at all; phase 1 sends flat
		// out against a long result hold.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			sender_idle = (ph % 4 != 0) && (ph != 1);
			result_idle <= (ph % 4 != 0);
			kind = (ph == 5) ? NOISE_CFG : (ph % 6 == 3) ? EXTREME_CFG : SLICE_CFG;
			for (int k = 0; k < ssam_pkg::NDIM; k++)
				pick_dim(k, kind);
			load_slice();
			if (ph == 1)
				hold_ticket <= hold_ticket + 1;
			for (int i = 0; i < PHASE_ITEMS; i++)
				push_item(pick_coord(0), pick_coord(1), pick_coord(2), pick_coord(3),
					32'($urandom()));
			wait_drain();
		end

		if (mismatch_count == 0 && pending_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: strided_slice_address_map.f
src/ssam_pkg.sv
src/ssam_fifo.sv
src/ssam_front.sv
src/ssam_back.sv
src/strided_slice_address_map.sv
tb/sv/slice_map_checker.sv
tb/sv/tb.sv
